/* hw/rtl/fdiv_pkg.sv */
// Types and constants shared by the signed fixed-point divider.
`default_nettype none

package fdiv_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_W      = DATA_W + FRAC_BITS;
  localparam int unsigned STEP_BITS  = 2;
  localparam int unsigned NUM_STAGES = (DIV_W + STEP_BITS) / STEP_BITS;
  localparam int unsigned DVD_W      = NUM_STAGES * STEP_BITS;

  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic                     div_by_zero;
    logic                     overflow;
  } res_t;

  // Partial remainder, dividend bits shifting out and quotient bits shifting in.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DVD_W-1:0]  dq;
    logic [DATA_W-1:0] dmag;
    logic              qneg;
    logic              dbz;
  } work_t;

endpackage

`default_nettype wire

/* hw/rtl/fdiv_prep.sv */
// Input stage: operand magnitudes, result sign and zero-divisor detect.
`default_nettype none

module fdiv_prep (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fdiv_pkg::req_t req_i,
  output logic               valid_o,
  output fdiv_pkg::work_t    work_o
);
  import fdiv_pkg::*;

  logic              nneg, dneg;
  logic [DATA_W-1:0] nmag, dmag;
  work_t             work_d, work_q;
  logic              valid_q;

  always_comb begin
    nneg = req_i.numerator[DATA_W-1];
    dneg = req_i.denominator[DATA_W-1];
    nmag = nneg ? DATA_W'(-req_i.numerator) : DATA_W'(req_i.numerator);
    dmag = dneg ? DATA_W'(-req_i.denominator) : DATA_W'(req_i.denominator);
    work_d.rem  = '0;
    work_d.dq   = DVD_W'(nmag) << FRAC_BITS;
    work_d.dmag = dmag;
    work_d.qneg = nneg ^ dneg;
    work_d.dbz  = (dmag == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

/* hw/rtl/fdiv_stage.sv */
// One divider pipeline stage: STEP_BITS restoring shift-subtract steps.
`default_nettype none

module fdiv_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fdiv_pkg::work_t work_i,
  output logic               valid_o,
  output fdiv_pkg::work_t    work_o
);
  import fdiv_pkg::*;

  work_t           work_d, work_q;
  logic            valid_q;
  logic [DATA_W:0] trial;
  logic            ge;

  always_comb begin
    work_d = work_i;
    trial  = '0;
    ge     = 1'b0;
    for (int unsigned i = 0; i < STEP_BITS; i++) begin
      trial = {work_d.rem, work_d.dq[DVD_W-1]};
      ge    = (trial >= {1'b0, work_d.dmag});
      work_d.rem = ge ? DATA_W'(trial - {1'b0, work_d.dmag}) : trial[DATA_W-1:0];
      work_d.dq  = {work_d.dq[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

/* hw/rtl/fdiv_post.sv */
// Output stage: sign restore, overflow check, zero-divisor result.
`default_nettype none

module fdiv_post (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fdiv_pkg::work_t work_i,
  output logic               valid_o,
  output fdiv_pkg::res_t     res_o
);
  import fdiv_pkg::*;

  res_t res_d, res_q;
  logic valid_q;
  logic hi_nz, lo_nz;

  always_comb begin
    hi_nz = |work_i.dq[DVD_W-1:DATA_W];
    lo_nz = |work_i.dq[DATA_W-2:0];
    if (work_i.dbz) begin
      res_d.quotient    = '0;
      res_d.div_by_zero = 1'b1;
      res_d.overflow    = 1'b0;
    end else if (work_i.qneg) begin
      res_d.quotient    = DATA_W'(-work_i.dq[DATA_W-1:0]);
      res_d.div_by_zero = 1'b0;
      res_d.overflow    = hi_nz | (work_i.dq[DATA_W-1] & lo_nz);
    end else begin
      res_d.quotient    = work_i.dq[DATA_W-1:0];
      res_d.div_by_zero = 1'b0;
      res_d.overflow    = hi_nz | work_i.dq[DATA_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* hw/rtl/fixed_div_16_16.sv */
// Signed Q16.16 fixed-point divider, fully pipelined.
//
// Request channel: req_valid_i / req_ready_o carry numerator and denominator.
// Result channel: res_valid_o / res_ready_i carry the quotient (low 32 bits of
// (numerator << 16) / denominator, truncated toward zero), div_by_zero and
// overflow. A zero denominator gives quotient 0 with div_by_zero set.
// Pipeline: one input stage, one shift-subtract stage per two quotient bits,
// one output register.
// Throughput: one request per cycle while the output is not stalled; results leave in request order.
// Stall: the whole pipeline holds while the output register holds a result
// that is not taken; req_ready_o is low only then. Bubbles travel as
// invalid stages and nothing is lost or repeated.
// Reset: clears all stage valid bits; no result is pending afterwards and
// the block accepts a request in the first cycle after reset is released.
`default_nettype none

module fixed_div_16_16 (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire fdiv_pkg::req_t req_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output fdiv_pkg::res_t res_o
);
  import fdiv_pkg::*;

  logic  en;
  logic  valid [NUM_STAGES+1];
  work_t work  [NUM_STAGES+1];

  assign en          = !res_valid_o || res_ready_i;
  assign req_ready_o = en;

  fdiv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_valid_i),
    .req_i   (req_i),
    .valid_o (valid[0]),
    .work_o  (work[0])
  );

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    fdiv_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[s]),
      .work_i  (work[s]),
      .valid_o (valid[s+1]),
      .work_o  (work[s+1])
    );
  end

  fdiv_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid[NUM_STAGES]),
    .work_i  (work[NUM_STAGES]),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
